>>> rtl/srt_pkg.sv
// Shared types and constants for the sorted record table.
// Used by srt_cell, srt_prefix and sorted_record_table_top; no dependencies.
package srt_pkg;

	localparam int DEPTH  = 64;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int LVLS   = $clog2(DEPTH);
	localparam int YEAR_W = 16;
	localparam int FLOW_W = 32;

	typedef enum logic [1:0] {
		ACT_INSERT  = 2'd0,
		ACT_REMOVE  = 2'd1,
		ACT_RST_CUR = 2'd2,
		ACT_ADV     = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_NOTFOUND = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_UPD  = 1'b1
	} state_t;

	// per-operation controls broadcast to every cell during the update cycle
	typedef struct packed {
		logic upd;
		logic ins;
		logic rem;
		logic clr;
		logic rst;
		logic adv;
	} cell_ctl_t;

endpackage

>>> rtl/srt_cell.sv
// One slot of the sorted chain: holds a record, its compare flags and the cursor token.
// Depends on srt_pkg.
module srt_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cap,
	input  srt_pkg::cell_ctl_t        ctl,
	input  logic                      occ,
	input  logic                      head,
	input  logic [srt_pkg::YEAR_W-1:0] cmp_year,
	input  logic [srt_pkg::FLOW_W-1:0] cmp_flow,
	input  logic [srt_pkg::YEAR_W-1:0] new_year,
	input  logic [srt_pkg::FLOW_W-1:0] new_flow,
	input  logic [srt_pkg::YEAR_W-1:0] left_year,
	input  logic [srt_pkg::FLOW_W-1:0] left_flow,
	input  logic                      left_ge,
	input  logic                      left_token,
	input  logic [srt_pkg::YEAR_W-1:0] right_year,
	input  logic [srt_pkg::FLOW_W-1:0] right_flow,
	input  logic                      first_hit,
	output logic [srt_pkg::YEAR_W-1:0] year_q,
	output logic [srt_pkg::FLOW_W-1:0] flow_q,
	output logic                      ge_q,
	output logic                      match_q,
	output logic                      token_q
);
	import srt_pkg::*;

	// empty slots count as "greater or equal" so the insert point is the first set bit
	always_ff @(posedge clk) begin
		if (cap) begin
			ge_q    <= !occ || (flow_q >= cmp_flow);
			match_q <= occ && (year_q == cmp_year);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.upd && ctl.ins && ge_q) begin
			if (left_ge) begin
				year_q <= left_year;
				flow_q <= left_flow;
			end else begin
				year_q <= new_year;
				flow_q <= new_flow;
			end
		end else if (ctl.upd && ctl.rem && first_hit) begin
			year_q <= right_year;
			flow_q <= right_flow;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_q <= 1'b0;
		end else if (ctl.upd) begin
			if (ctl.clr) begin
				token_q <= 1'b0;
			end else if (ctl.rst) begin
				token_q <= head;
			end else if (ctl.adv) begin
				token_q <= left_token && occ;
			end
		end
	end

endmodule

>>> rtl/srt_prefix.sv
// Log-depth prefix OR: bit i of the result is set when any input bit at or below i is set.
// Depends on srt_pkg.
module srt_prefix (
	input  logic [srt_pkg::DEPTH-1:0] bits,
	output logic [srt_pkg::DEPTH-1:0] pfx
);
	import srt_pkg::*;

	logic [DEPTH-1:0] lvl [0:LVLS];

	assign lvl[0] = bits;

	for (genvar k = 0; k < LVLS; k++) begin : g_lvl
		for (genvar i = 0; i < DEPTH; i++) begin : g_bit
			if (i >= (1 << k)) begin : g_or
				assign lvl[k+1][i] = lvl[k][i] | lvl[k][i-(1<<k)];
			end else begin : g_pass
				assign lvl[k+1][i] = lvl[k][i];
			end
		end
	end

	assign pfx = lvl[LVLS];

endmodule

>>> rtl/sorted_record_table_top.sv
// Sorted record table top level: control, cell chain and result register.
// Depends on srt_pkg, srt_cell and srt_prefix.

// Holds up to DEPTH (year, flow) records in ascending flow order in a chain of cells,
// one record per cell. At the accepting edge every cell compares its record with the
// new flow and year in parallel, and on the next edge the cells from the insert point
// or the first match onward shift one place at once (right for an insert, left for a
// remove), and the one-hot cursor token moves or is cleared. The result is then held
// pending and loaded into the output register once it is free, which is also when the next item can be taken; the input
// stalls only while an update is in flight or an older result still occupies the
// output register. No clearing pass is needed after reset.
module sorted_record_table_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 action,
	input  logic [srt_pkg::YEAR_W-1:0] year_value,
	input  logic [srt_pkg::FLOW_W-1:0] flow_value,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [1:0]                 status,
	output logic [srt_pkg::CNT_W-1:0]  entry_count,
	output logic                       cursor_valid,
	output logic [srt_pkg::YEAR_W-1:0] cursor_year,
	output logic [srt_pkg::FLOW_W-1:0] cursor_flow
);
	import srt_pkg::*;

	state_t state_q, state_d;

	logic               accept;
	logic               load;
	logic               pend_q;
	logic [CNT_W-1:0]   count_q;
	logic [1:0]         act_q;
	logic [YEAR_W-1:0]  year_q;
	logic [FLOW_W-1:0]  flow_q;
	logic               found;
	logic               is_full;
	cell_ctl_t          ctl;
	status_t            status_d;
	status_t            status_q;
	logic [CNT_W-1:0]   count_d;

	logic [DEPTH-1:0]   occ;
	logic [DEPTH-1:0]   head;
	logic [DEPTH-1:0]   ge;
	logic [DEPTH-1:0]   match;
	logic [DEPTH-1:0]   hit_pfx;
	logic [DEPTH-1:0]   token;
	logic [YEAR_W-1:0]  c_year [DEPTH];
	logic [FLOW_W-1:0]  c_flow [DEPTH];

	logic               out_valid_q;
	status_t            out_status_q;
	logic [CNT_W-1:0]   out_count_q;
	logic               out_cv_q;
	logic [YEAR_W-1:0]  out_year_q;
	logic [FLOW_W-1:0]  out_flow_q;
	logic               sel_cv;
	logic [YEAR_W-1:0]  sel_year;
	logic [FLOW_W-1:0]  sel_flow;

	// result slot frees up when empty or being transferred this cycle
	assign load     = pend_q && (!out_valid_q || !out_stall);
	assign in_stall = (state_q != S_IDLE) || (pend_q && !load);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (accept) state_d = S_UPD;
			S_UPD:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q  <= action;
			year_q <= year_value;
			flow_q <= flow_value;
		end
	end

	assign found   = hit_pfx[DEPTH-1];
	assign is_full = (count_q >= CNT_W'(DEPTH));

	always_comb begin
		ctl      = '0;
		status_d = ST_OK;
		count_d  = count_q;
		ctl.upd  = (state_q == S_UPD);
		case (act_q)
			ACT_INSERT: begin
				ctl.clr = 1'b1;
				ctl.ins = !is_full;
				if (is_full) begin
					status_d = ST_FULL;
				end else begin
					count_d = count_q + CNT_W'(1);
				end
			end
			ACT_REMOVE: begin
				ctl.clr = 1'b1;
				ctl.rem = found;
				if (found) begin
					count_d = count_q - CNT_W'(1);
				end else begin
					status_d = ST_NOTFOUND;
				end
			end
			ACT_RST_CUR: ctl.rst = 1'b1;
			ACT_ADV:     ctl.adv = 1'b1;
			default:     ctl.clr = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			pend_q  <= 1'b0;
		end else begin
			if (ctl.upd) begin
				count_q <= count_d;
			end
			if (ctl.upd) begin
				pend_q <= 1'b1;
			end else if (load) begin
				pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.upd) begin
			status_q <= status_d;
		end
	end

	// cell chain
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign occ[i] = (count_q > CNT_W'(i));
		if (i == 0) begin : g_head
			assign head[i] = (count_q != '0);
		end else begin : g_body
			assign head[i] = 1'b0;
		end

		logic [YEAR_W-1:0] l_year, r_year;
		logic [FLOW_W-1:0] l_flow, r_flow;
		logic              l_ge, l_token;

		if (i == 0) begin : g_left_end
			assign l_year  = year_q;
			assign l_flow  = flow_q;
			assign l_ge    = 1'b0;
			assign l_token = 1'b0;
		end else begin : g_left
			assign l_year  = c_year[i-1];
			assign l_flow  = c_flow[i-1];
			assign l_ge    = ge[i-1];
			assign l_token = token[i-1];
		end

		if (i == DEPTH - 1) begin : g_right_end
			assign r_year = c_year[i];
			assign r_flow = c_flow[i];
		end else begin : g_right
			assign r_year = c_year[i+1];
			assign r_flow = c_flow[i+1];
		end

		srt_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cap        (accept),
			.ctl        (ctl),
			.occ        (occ[i]),
			.head       (head[i]),
			.cmp_year   (year_value),
			.cmp_flow   (flow_value),
			.new_year   (year_q),
			.new_flow   (flow_q),
			.left_year  (l_year),
			.left_flow  (l_flow),
			.left_ge    (l_ge),
			.left_token (l_token),
			.right_year (r_year),
			.right_flow (r_flow),
			.first_hit  (hit_pfx[i]),
			.year_q     (c_year[i]),
			.flow_q     (c_flow[i]),
			.ge_q       (ge[i]),
			.match_q    (match[i]),
			.token_q    (token[i])
		);
	end

	srt_prefix u_prefix (
		.bits (match),
		.pfx  (hit_pfx)
	);

	// token is one-hot or zero, so an AND-OR picks the cursor record
	always_comb begin
		sel_cv   = |token;
		sel_year = '0;
		sel_flow = '0;
		for (int i = 0; i < DEPTH; i++) begin
			sel_year = sel_year | (c_year[i] & {YEAR_W{token[i]}});
			sel_flow = sel_flow | (c_flow[i] & {FLOW_W{token[i]}});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_status_q <= status_q;
			out_count_q  <= count_q;
			out_cv_q     <= sel_cv;
			out_year_q   <= sel_year;
			out_flow_q   <= sel_flow;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign entry_count  = out_count_q;
	assign cursor_valid = out_cv_q;
	assign cursor_year  = out_year_q;
	assign cursor_flow  = out_flow_q;

	a_token_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(token))
		else $error("cursor token on more than one cell");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above table depth");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.upd |=> (count_q == $past(count_q)) || (count_q == $past(count_q) + CNT_W'(1))
			|| (count_q == $past(count_q) - CNT_W'(1)))
		else $error("entry count moved by more than one");

	a_clr_token: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.upd && ctl.clr) |=> (token == '0))
		else $error("cursor still on after insert or remove");

	a_accept_upd: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_UPD) && pend_q == $past(pend_q && !load))
		else $error("accepted transfer did not start an update");

endmodule

>>> tb/tb_sorted_record_table_top.sv
// Self-checking testbench for sorted_record_table_top: directed and random table operations.
// A shadow copy of the table predicts each result, and results are checked in order.
// Depends on srt_pkg and the sorted_record_table_top RTL.
`timescale 1ns / 100ps

module tb_sorted_record_table_top;
	import srt_pkg::*;

	localparam int NUM_RANDOM   = 1250;
	localparam int IDLE_LIMIT   = 400;
	localparam int DRAIN_CYCLES = 12;

	typedef enum int {
		PH_FILL  = 0,
		PH_DRAIN = 1,
		PH_WALK  = 2,
		PH_MIXED = 3
	} phase_t;

	typedef struct {
		action_t            act;
		logic [YEAR_W-1:0]  year;
		logic [FLOW_W-1:0]  flow;
	} table_op_t;

	typedef struct {
		status_t            st;
		logic [CNT_W-1:0]   count;
		logic               cur_valid;
		logic [YEAR_W-1:0]  cur_year;
		logic [FLOW_W-1:0]  cur_flow;
	} table_view_t;

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               in_valid     = 1'b0;
	logic               in_stall;
	logic [1:0]         action       = ACT_INSERT;
	logic [YEAR_W-1:0]  year_value   = '0;
	logic [FLOW_W-1:0]  flow_value   = '0;
	logic               out_valid;
	logic               out_stall    = 1'b0;
	logic [1:0]         status;
	logic [CNT_W-1:0]   entry_count;
	logic               cursor_valid;
	logic [YEAR_W-1:0]  cursor_year;
	logic [FLOW_W-1:0]  cursor_flow;

	// shadow of the table, advanced once per accepted transfer
	logic [FLOW_W-1:0]  shadow_flow [DEPTH];
	logic [YEAR_W-1:0]  shadow_year [DEPTH];
	int                 shadow_count     = 0;
	int                 shadow_cursor    = 0;
	bit                 shadow_cursor_on = 1'b0;

	table_op_t          pending_ops[$];
	table_view_t        expected_views[$];
	table_op_t          cur_op;
	table_view_t        want;

	// years held, as the stimulus generator sees them (for removes that hit)
	logic [YEAR_W-1:0]  gen_years[$];

	int                 total_ops    = 0;
	int                 ops_accepted = 0;
	int                 send_gap     = 0;
	bit                 send_calm    = 1'b0;
	int                 recv_hold    = 0;
	bit                 recv_calm    = 1'b0;
	int                 idle_cycles  = 0;
	bit                 failed       = 1'b0;

	sorted_record_table_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.year_value   (year_value),
		.flow_value   (flow_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.entry_count  (entry_count),
		.cursor_valid (cursor_valid),
		.cursor_year  (cursor_year),
		.cursor_flow  (cursor_flow)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// applies one operation to the shadow table and returns the result it produces
	function automatic table_view_t apply_table_op(input table_op_t op);
		table_view_t r;
		int          pos;
		int          i;
		r.st = ST_OK;
		pos  = 0;
		case (op.act)
			ACT_INSERT: begin
				shadow_cursor_on = 1'b0;
				if (shadow_count >= DEPTH) begin
					r.st = ST_FULL;
				end else begin
					// new record lands ahead of any equal flow
					while (pos < shadow_count && shadow_flow[pos] < op.flow)
						pos++;
					for (i = shadow_count; i > pos; i--) begin
						shadow_flow[i] = shadow_flow[i-1];
						shadow_year[i] = shadow_year[i-1];
					end
					shadow_flow[pos] = op.flow;
					shadow_year[pos] = op.year;
					shadow_count++;
				end
			end
			ACT_REMOVE: begin
				shadow_cursor_on = 1'b0;
				while (pos < shadow_count && shadow_year[pos] != op.year)
					pos++;
				if (pos >= shadow_count) begin
					r.st = ST_NOTFOUND;
				end else begin
					for (i = pos; i + 1 < shadow_count; i++) begin
						shadow_flow[i] = shadow_flow[i+1];
						shadow_year[i] = shadow_year[i+1];
					end
					shadow_count--;
				end
			end
			ACT_RST_CUR: begin
				shadow_cursor    = 0;
				shadow_cursor_on = (shadow_count != 0);
			end
			default: begin
				if (shadow_cursor_on && shadow_cursor + 1 < shadow_count)
					shadow_cursor++;
				else
					shadow_cursor_on = 1'b0;
			end
		endcase
		r.count = CNT_W'(shadow_count);
		if (shadow_cursor_on && shadow_cursor < shadow_count) begin
			r.cur_valid = 1'b1;
			r.cur_year  = shadow_year[shadow_cursor];
			r.cur_flow  = shadow_flow[shadow_cursor];
		end else begin
			r.cur_valid = 1'b0;
			r.cur_year  = '0;
			r.cur_flow  = '0;
		end
		return r;
	endfunction

	// queues one operation and tracks which years the table will hold
	function automatic void add_op(input action_t a, input logic [YEAR_W-1:0] y,
	                               input logic [FLOW_W-1:0] f);
		table_op_t op;
		int        i;
		op.act  = a;
		op.year = y;
		op.flow = f;
		pending_ops.push_back(op);
		if (a == ACT_INSERT && gen_years.size() < DEPTH) begin
			gen_years.push_back(y);
		end else if (a == ACT_REMOVE) begin
			for (i = 0; i < gen_years.size(); i++) begin
				if (gen_years[i] == y) begin
					gen_years.delete(i);
					break;
				end
			end
		end
	endfunction

	function automatic logic [YEAR_W-1:0] pick_year();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return '1;
			2, 3:    return YEAR_W'($urandom_range(0, 15));
			default: return YEAR_W'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic logic [FLOW_W-1:0] pick_flow();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return '1;
			// few distinct values so equal flows are common
			2:       return FLOW_W'($urandom_range(0, 7)) << 8;
			3:       return FLOW_W'($urandom_range(0, 255));
			default: return FLOW_W'($urandom);
		endcase
	endfunction

	function automatic logic [YEAR_W-1:0] held_year();
		if (gen_years.size() == 0)
			return pick_year();
		return gen_years[$urandom_range(0, gen_years.size() - 1)];
	endfunction

	function automatic void add_random_op(input phase_t ph);
		int r;
		r = $urandom_range(0, 99);
		case (ph)
			PH_FILL: begin
				if (r < 70)      add_op(ACT_INSERT, pick_year(), pick_flow());
				else if (r < 80) add_op(ACT_REMOVE, held_year(), FLOW_W'($urandom));
				else if (r < 85) add_op(ACT_RST_CUR, pick_year(), FLOW_W'($urandom));
				else             add_op(ACT_ADV, pick_year(), FLOW_W'($urandom));
			end
			PH_DRAIN: begin
				if (r < 70)      add_op(ACT_REMOVE, held_year(), FLOW_W'($urandom));
				else if (r < 78) add_op(ACT_REMOVE, pick_year(), FLOW_W'($urandom));
				else if (r < 88) add_op(ACT_INSERT, pick_year(), pick_flow());
				else if (r < 93) add_op(ACT_RST_CUR, pick_year(), FLOW_W'($urandom));
				else             add_op(ACT_ADV, pick_year(), FLOW_W'($urandom));
			end
			PH_WALK: begin
				if (r < 8)       add_op(ACT_RST_CUR, pick_year(), FLOW_W'($urandom));
				else if (r < 90) add_op(ACT_ADV, pick_year(), FLOW_W'($urandom));
				else if (r < 95) add_op(ACT_INSERT, pick_year(), pick_flow());
				else             add_op(ACT_REMOVE, held_year(), FLOW_W'($urandom));
			end
			default: begin
				if (r < 35)      add_op(ACT_INSERT, pick_year(), pick_flow());
				else if (r < 58) add_op(ACT_REMOVE, held_year(), FLOW_W'($urandom));
				else if (r < 65) add_op(ACT_REMOVE, pick_year(), FLOW_W'($urandom));
				else if (r < 75) add_op(ACT_RST_CUR, pick_year(), FLOW_W'($urandom));
				else             add_op(ACT_ADV, pick_year(), FLOW_W'($urandom));
			end
		endcase
	endfunction

	initial begin
		int     n_random;
		int     len;
		int     k;
		phase_t ph;

		// directed: empty-table corner cases, field extremes, equal flows, cursor edges
		add_op(ACT_REMOVE,  16'h0000, 32'h0000_0000);
		add_op(ACT_RST_CUR, 16'hFFFF, 32'hFFFF_FFFF);
		add_op(ACT_ADV,     16'h0000, 32'h0000_0000);
		add_op(ACT_INSERT,  16'h0000, 32'h0000_0000);
		add_op(ACT_INSERT,  16'hFFFF, 32'hFFFF_FFFF);
		add_op(ACT_INSERT,  16'h04D2, 32'h0000_0000);
		add_op(ACT_INSERT,  16'h0007, 32'h8000_0000);
		add_op(ACT_INSERT,  16'h0007, 32'h0000_0100);
		add_op(ACT_RST_CUR, 16'h0000, 32'h0000_0000);
		for (k = 0; k < 6; k++)
			add_op(ACT_ADV, 16'h5555, 32'hAAAA_AAAA);
		add_op(ACT_RST_CUR, 16'h0000, 32'h0000_0000);
		add_op(ACT_ADV,     16'h0000, 32'h0000_0000);
		add_op(ACT_REMOVE,  16'h0007, 32'h0000_0000);
		add_op(ACT_ADV,     16'h0000, 32'h0000_0000);
		add_op(ACT_REMOVE,  16'h03E7, 32'h0000_0000);
		add_op(ACT_INSERT,  16'h0000, 32'hFFFF_FFFF);
		add_op(ACT_REMOVE,  16'hFFFF, 32'h0000_0000);
		add_op(ACT_RST_CUR, 16'h0000, 32'h0000_0000);

		// random: phases of filling, draining, cursor walks and mixed traffic
		n_random = 0;
		ph       = PH_FILL;
		while (n_random < NUM_RANDOM) begin
			len = (ph == PH_FILL && n_random == 0) ? 90 : $urandom_range(20, 100);
			if (ph == PH_WALK) begin
				add_op(ACT_RST_CUR, pick_year(), FLOW_W'($urandom));
				n_random++;
			end
			for (k = 0; k < len; k++)
				add_random_op(ph);
			n_random += len;
			ph = phase_t'($urandom_range(0, 3));
		end
		total_ops = pending_ops.size();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(negedge clk);
		while (ops_accepted < total_ops || expected_views.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (!failed)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// driver: predicts on each accepted transfer, then launches the next item after its gap
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_views.push_back(apply_table_op(cur_op));
				ops_accepted++;
			end
			if (!(in_valid && in_stall)) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_ops.size() != 0) begin
					cur_op = pending_ops.pop_front();
					action     <= cur_op.act;
					year_value <= cur_op.year;
					flow_value <= cur_op.flow;
					in_valid   <= 1'b1;
					if ($urandom_range(0, 39) == 0)
						send_calm = !send_calm;
					send_gap = send_calm ? 0 : $urandom_range(0, 7);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each accepted result against the oldest prediction
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_views.size() == 0) begin
					$error("result with nothing expected: status %0d entry_count %0d",
					       status, entry_count);
					failed = 1'b1;
				end else begin
					want = expected_views.pop_front();
					if (status !== want.st) begin
						$error("status: expected %0d, got %0d", want.st, status);
						failed = 1'b1;
					end
					if (entry_count !== want.count) begin
						$error("entry_count: expected %0d, got %0d", want.count, entry_count);
						failed = 1'b1;
					end
					if (cursor_valid !== want.cur_valid) begin
						$error("cursor_valid: expected %0b, got %0b", want.cur_valid,
						       cursor_valid);
						failed = 1'b1;
					end
					if (cursor_year !== want.cur_year) begin
						$error("cursor_year: expected %h, got %h", want.cur_year, cursor_year);
						failed = 1'b1;
					end
					if (cursor_flow !== want.cur_flow) begin
						$error("cursor_flow: expected %h, got %h", want.cur_flow, cursor_flow);
						failed = 1'b1;
					end
				end
				if ($urandom_range(0, 39) == 0)
					recv_calm = !recv_calm;
				recv_hold = recv_calm ? 0 : $urandom_range(0, 7);
			end else if (recv_hold > 0) begin
				recv_hold--;
			end
			out_stall <= (recv_hold > 0);
		end
	end

	// watchdog: too long without any transfer on either side ends the run
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

endmodule

>>> sim.f
rtl/srt_pkg.sv
rtl/srt_cell.sv
rtl/srt_prefix.sv
rtl/sorted_record_table_top.sv
tb/tb_sorted_record_table_top.sv
